>>> src/overlap_alignment_engine_assert.svh
`ifndef OVERLAP_ALIGNMENT_ENGINE_ASSERT_SVH
`define OVERLAP_ALIGNMENT_ENGINE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define OAE_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
// Next-cycle implication.
`define OAE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`endif

>>> src/oae_pkg.sv
package oae_pkg;
    localparam int MaxLen = 32;
    localparam int SymbolBits = 8;
    localparam int ScoreW = 11;

    typedef enum logic [1:0] {
        ACT_FIRST = 2'd0,
        ACT_SECOND = 2'd1,
        ACT_ALIGN = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MV_UP = 2'd0,
        MV_LEFT = 2'd1,
        MV_DIAG = 2'd2,
        MV_NONE = 2'd3
    } t_move;

    localparam logic CFG_MATCH = 1'b0;
    localparam logic CFG_PENALTY = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] symbol;
    } t_in_item;

    typedef struct packed {
        logic signed [10:0] score;
        logic [7:0] top_symbol;
        logic top_gap;
        logic [7:0] bottom_symbol;
        logic bottom_gap;
        logic last;
        logic no_alignment;
        logic overflow;
    } t_out_item;
endpackage

>>> src/oae_ram.sv
module oae_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> src/overlap_alignment_engine.sv
// Overlap alignment engine.
// Input channel (i_in_valid/o_in_ready, t_in_item): action 0 appends a symbol
// to the first sequence, action 1 to the second; action 2 aligns. Symbols
// past MAX_LEN are dropped and set a sticky overflow flag.
// Input ready only while idle with no item pending at the output.
// Configuration channel (i_cfg_valid/o_cfg_ready): index 0 match score,
// index 1 gap/mismatch penalty; always ready, and the user must write it
// only while idle; the block does not enforce this. Align: row 0 first;
// each grid row a setup state, then per cell a read and a compute/write-back
// state, as the score-row memory read is registered; the best-end search
// reads and compares per column; the traceback reads and steps into a column
// memory; then each column is read out and registered at the output.
// Empty second sequence gives one item flagged no_alignment.
// Output channel (o_out_valid/i_out_ready, t_out_item): one registered item,
// held while the receiver stalls; the next column waits for it.
// Reset (i_rst_n low, synchronous) clears lengths, flag, output valid and
// control and sets match 1, penalty -2; memories are undefined until written.
module overlap_alignment_engine #(
    parameter int MAX_LEN = oae_pkg::MaxLen,
    parameter int SYMBOL_BITS = oae_pkg::SymbolBits
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  oae_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output oae_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [4:0]          i_cfg_data
);
    localparam int AW = $clog2(MAX_LEN) > 0 ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int RD = MAX_LEN + 1;
    localparam int RW = $clog2(RD);
    localparam int DD = MAX_LEN * MAX_LEN;
    localparam int DW = $clog2(DD) > 0 ? $clog2(DD) : 1;
    localparam int CD = 2 * MAX_LEN;
    localparam int CW = $clog2(CD);
    localparam int SW = oae_pkg::ScoreW;

    typedef enum logic [3:0] {
        S_IDLE, S_ROW0, S_ROWST, S_RDU, S_CELL, S_BRD, S_BCMP,
        S_TRD, S_TSTEP, S_ORD, S_OWAIT
    } t_state;

    t_state r_state;
    logic [3:0] r_match;
    logic signed [4:0] r_pen;
    logic [LW-1:0] r_len1, r_len2;
    logic r_ovf;
    logic [LW-1:0] r_i, r_j;
    logic signed [SW-1:0] r_left, r_diag, r_best;
    logic [LW-1:0] r_bestj;
    logic [CW:0] r_cnt, r_k;
    logic r_out_valid;
    oae_pkg::t_out_item r_out;

    // memories
    logic s1_we, s2_we, sr_we, dm_we, cb_we;
    logic [AW-1:0] s1_wa, s2_wa, s1_ra, s2_ra;
    logic [SYMBOL_BITS-1:0] s1_rd, s2_rd, sym_in;
    logic [RW-1:0] sr_wa, sr_ra;
    logic signed [SW-1:0] sr_wd, sr_rd;
    logic [DW-1:0] dm_wa, dm_ra;
    logic [1:0] dm_wd, dm_rd;
    logic [CW-1:0] cb_wa, cb_ra;
    logic [2*SYMBOL_BITS+1:0] cb_wd, cb_rd;

    assign sym_in = i_in_data.symbol[SYMBOL_BITS-1:0];

    oae_ram #(.DEPTH(MAX_LEN), .WIDTH(SYMBOL_BITS)) u_s1 (.i_clk, .i_we(s1_we),
        .i_waddr(s1_wa), .i_wdata(sym_in), .i_raddr(s1_ra), .o_rdata(s1_rd));
    oae_ram #(.DEPTH(MAX_LEN), .WIDTH(SYMBOL_BITS)) u_s2 (.i_clk, .i_we(s2_we),
        .i_waddr(s2_wa), .i_wdata(sym_in), .i_raddr(s2_ra), .o_rdata(s2_rd));
    oae_ram #(.DEPTH(RD), .WIDTH(SW)) u_row (.i_clk, .i_we(sr_we),
        .i_waddr(sr_wa), .i_wdata(sr_wd), .i_raddr(sr_ra), .o_rdata(sr_rd));
    oae_ram #(.DEPTH(DD), .WIDTH(2)) u_dir (.i_clk, .i_we(dm_we),
        .i_waddr(dm_wa), .i_wdata(dm_wd), .i_raddr(dm_ra), .o_rdata(dm_rd));
    oae_ram #(.DEPTH(CD), .WIDTH(2*SYMBOL_BITS+2)) u_col (.i_clk, .i_we(cb_we),
        .i_waddr(cb_wa), .i_wdata(cb_wd), .i_raddr(cb_ra), .o_rdata(cb_rd));

    logic in_acc;
    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign in_acc = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    logic signed [SW-1:0] pen_x, mat_x, up_v, left_v, diag_v, best_v;
    logic [1:0] mv_v;
    logic [LW-1:0] im1, jm1;
    assign pen_x = SW'(r_pen);
    assign mat_x = SW'({1'b0, r_match});
    assign im1 = r_i - LW'(1);
    assign jm1 = r_j - LW'(1);

    always_comb begin
        up_v = sr_rd + pen_x;
        left_v = r_left + pen_x;
        diag_v = r_diag + ((s1_rd == s2_rd) ? mat_x : pen_x);
        best_v = up_v;
        if (left_v > best_v) best_v = left_v;
        if (diag_v > best_v) best_v = diag_v;
        if (best_v == up_v) mv_v = oae_pkg::MV_UP;
        else if (best_v == left_v) mv_v = oae_pkg::MV_LEFT;
        else mv_v = oae_pkg::MV_DIAG;
    end

    // traceback move
    logic [1:0] tmv;
    assign tmv = (r_i == '0) ? oae_pkg::MV_LEFT : dm_rd;

    always_comb begin
        s1_we = in_acc && i_in_data.action == oae_pkg::ACT_FIRST && r_len1 < LW'(MAX_LEN);
        s2_we = in_acc && i_in_data.action == oae_pkg::ACT_SECOND && r_len2 < LW'(MAX_LEN);
        s1_wa = r_len1[AW-1:0];
        s2_wa = r_len2[AW-1:0];
        s1_ra = im1[AW-1:0];
        s2_ra = jm1[AW-1:0];
        sr_we = 1'b0;
        sr_wa = r_j[RW-1:0];
        sr_wd = best_v;
        sr_ra = r_j[RW-1:0];
        dm_we = 1'b0;
        dm_wa = DW'(im1[AW-1:0]) * DW'(MAX_LEN) + DW'(jm1[AW-1:0]);
        dm_wd = mv_v;
        dm_ra = dm_wa;
        cb_we = 1'b0;
        cb_wa = CW'(CD - 1) - r_cnt[CW-1:0];
        cb_wd = '0;
        cb_ra = CW'(CD) - r_cnt[CW-1:0] + r_k[CW-1:0];
        case (r_state)
            S_ROW0: begin
                sr_we = 1'b1;
                sr_wd = r_left;
            end
            S_ROWST: begin
                sr_we = 1'b1;
                sr_wa = '0;
                sr_wd = '0;
            end
            S_CELL: begin
                sr_we = 1'b1;
                dm_we = 1'b1;
            end
            S_TSTEP: begin
                cb_we = 1'b1;
                case (tmv)
                    oae_pkg::MV_UP: cb_wd = {s1_rd, 1'b0, {SYMBOL_BITS{1'b0}}, 1'b1};
                    oae_pkg::MV_LEFT: cb_wd = {{SYMBOL_BITS{1'b0}}, 1'b1, s2_rd, 1'b0};
                    default: cb_wd = {s1_rd, 1'b0, s2_rd, 1'b0};
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_match <= 4'd1;
            r_pen <= -5'sd2;
            r_len1 <= '0;
            r_len2 <= '0;
            r_ovf <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == oae_pkg::CFG_MATCH) r_match <= i_cfg_data[3:0];
                else r_pen <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_in_data.action)
                            oae_pkg::ACT_FIRST: begin
                                if (s1_we) r_len1 <= r_len1 + LW'(1);
                                else r_ovf <= 1'b1;
                            end
                            oae_pkg::ACT_SECOND: begin
                                if (s2_we) r_len2 <= r_len2 + LW'(1);
                                else r_ovf <= 1'b1;
                            end
                            oae_pkg::ACT_ALIGN: begin
                                if (r_len2 == '0) begin
                                    r_out <= '{score: '0, top_symbol: '0, top_gap: 1'b0,
                                               bottom_symbol: '0, bottom_gap: 1'b0,
                                               last: 1'b1, no_alignment: 1'b1,
                                               overflow: r_ovf};
                                    r_out_valid <= 1'b1;
                                end else begin
                                    r_j <= '0;
                                    r_left <= '0;
                                    r_state <= S_ROW0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_ROW0: begin
                    r_left <= r_left + pen_x;
                    if (r_j == r_len2) begin
                        r_i <= LW'(1);
                        r_state <= (r_len1 == '0) ? S_BRD : S_ROWST;
                        r_j <= LW'(1);
                    end else begin
                        r_j <= r_j + LW'(1);
                    end
                end
                S_ROWST: begin
                    // column 0 is always zero
                    r_diag <= '0;
                    r_left <= '0;
                    r_j <= LW'(1);
                    r_state <= S_RDU;
                end
                S_RDU: r_state <= S_CELL;
                S_CELL: begin
                    r_diag <= sr_rd;
                    r_left <= best_v;
                    if (r_j == r_len2) begin
                        if (r_i == r_len1) begin
                            r_j <= LW'(1);
                            r_state <= S_BRD;
                        end else begin
                            r_i <= r_i + LW'(1);
                            r_state <= S_ROWST;
                        end
                    end else begin
                        r_j <= r_j + LW'(1);
                        r_state <= S_RDU;
                    end
                end
                S_BRD: r_state <= S_BCMP;
                S_BCMP: begin
                    if (r_j == LW'(1) || sr_rd > r_best) begin
                        r_best <= sr_rd;
                        r_bestj <= r_j;
                    end
                    if (r_j == r_len2) begin
                        r_i <= r_len1;
                        r_cnt <= '0;
                        r_state <= S_TRD;
                    end else begin
                        r_j <= r_j + LW'(1);
                        r_state <= S_BRD;
                    end
                end
                S_TRD: begin
                    if (r_cnt == '0 && r_j != r_bestj) begin
                        r_j <= r_bestj;
                    end else begin
                        r_state <= S_TSTEP;
                    end
                end
                S_TSTEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (tmv)
                        oae_pkg::MV_UP: r_i <= im1;
                        oae_pkg::MV_LEFT: r_j <= jm1;
                        default: begin
                            r_i <= im1;
                            r_j <= jm1;
                        end
                    endcase
                    if ((tmv != oae_pkg::MV_UP && r_j == LW'(1)) ||
                        r_cnt == (CW+1)'(CD - 1)) begin
                        r_k <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_state <= S_TRD;
                    end
                end
                S_ORD: begin
                    if (!r_out_valid || i_out_ready) r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    r_out.score <= r_best;
                    r_out.top_symbol <= 8'(cb_rd[2*SYMBOL_BITS+1 -: SYMBOL_BITS]);
                    r_out.top_gap <= cb_rd[SYMBOL_BITS+1];
                    r_out.bottom_symbol <= 8'(cb_rd[SYMBOL_BITS:1]);
                    r_out.bottom_gap <= cb_rd[0];
                    r_out.last <= (r_k + 1'b1 == r_cnt);
                    r_out.no_alignment <= 1'b0;
                    r_out.overflow <= r_ovf;
                    r_out_valid <= 1'b1;
                    r_k <= r_k + 1'b1;
                    r_state <= (r_k + 1'b1 == r_cnt) ? S_IDLE : S_ORD;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> src/oae_checker.sv
`include "overlap_alignment_engine_assert.svh"
module oae_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input oae_pkg::t_out_item o_out_data
);
    logic out_stall, out_mid;
    assign out_stall = o_out_valid && !i_out_ready;
    assign out_mid = o_out_valid && i_out_ready && !o_out_data.last;

    `OAE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_data))
    `OAE_ASSERT_IMP(a_noal_last, i_clk, i_rst_n, o_out_valid && o_out_data.no_alignment, o_out_data.last)
    `OAE_ASSERT_IMP(a_gap_excl, i_clk, i_rst_n, o_out_valid, !(o_out_data.top_gap && o_out_data.bottom_gap))
    `OAE_ASSERT_NEXT(a_busy_mid, i_clk, i_rst_n, out_mid, !o_in_ready)
endmodule

bind overlap_alignment_engine oae_checker u_oae_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_in_ready(o_in_ready),
    .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
);

>>> bench/overlap_alignment_engine_tb.sv
module overlap_alignment_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    oae_pkg::t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    oae_pkg::t_out_item o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_index;
    logic [4:0] i_cfg_data;

    overlap_alignment_engine u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    localparam int CycleLimit = 2000000;

    // predictor state
    logic [3:0] mdl_match;
    logic signed [4:0] mdl_pen;
    logic [7:0] mdl_seq_a [oae_pkg::MaxLen];
    logic [7:0] mdl_seq_b [oae_pkg::MaxLen];
    int mdl_len_a;
    int mdl_len_b;
    logic mdl_ovf;

    oae_pkg::t_out_item column_queue [$];
    int mismatches;
    int cycles;
    int idle_pct_in;
    int stall_pct_out;
    logic hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void queue_col(input oae_pkg::t_out_item c);
        column_queue.insert(column_queue.size(), c);
    endfunction

    task automatic predict_align();
        int row [oae_pkg::MaxLen + 1];
        oae_pkg::t_move dirs [oae_pkg::MaxLen][oae_pkg::MaxLen];
        oae_pkg::t_out_item cols [$];
        oae_pkg::t_out_item c;
        int pen, mat, dprev, up, lf, dg, bst, best, best_j, i, j;
        oae_pkg::t_move mv;
        pen = mdl_pen;
        mat = mdl_match;
        if (mdl_len_b == 0) begin
            c = '0;
            c.last = 1'b1;
            c.no_alignment = 1'b1;
            c.overflow = mdl_ovf;
            queue_col(c);
            return;
        end
        row[0] = 0;
        for (j = 1; j <= mdl_len_b; j++) row[j] = row[j-1] + pen;
        for (i = 1; i <= mdl_len_a; i++) begin
            dprev = row[0];
            row[0] = 0;
            for (j = 1; j <= mdl_len_b; j++) begin
                up = row[j] + pen;
                lf = row[j-1] + pen;
                dg = dprev + ((mdl_seq_a[i-1] == mdl_seq_b[j-1]) ? mat : pen);
                bst = up;
                if (lf > bst) bst = lf;
                if (dg > bst) bst = dg;
                if (bst == up) mv = oae_pkg::MV_UP;
                else if (bst == lf) mv = oae_pkg::MV_LEFT;
                else mv = oae_pkg::MV_DIAG;
                dirs[i-1][j-1] = mv;
                dprev = row[j];
                row[j] = bst;
            end
        end
        best_j = 1;
        best = row[1];
        for (j = 2; j <= mdl_len_b; j++)
            if (row[j] > best) begin
                best = row[j];
                best_j = j;
            end
        i = mdl_len_a;
        j = best_j;
        while (j > 0 && cols.size() < 2 * oae_pkg::MaxLen) begin
            mv = (i == 0) ? oae_pkg::MV_LEFT : dirs[i-1][j-1];
            c = '0;
            c.score = best[10:0];
            c.overflow = mdl_ovf;
            if (mv == oae_pkg::MV_UP) begin
                c.top_symbol = mdl_seq_a[i-1];
                c.bottom_gap = 1'b1;
                i--;
            end else if (mv == oae_pkg::MV_LEFT) begin
                c.top_gap = 1'b1;
                c.bottom_symbol = mdl_seq_b[j-1];
                j--;
            end else begin
                c.top_symbol = mdl_seq_a[i-1];
                c.bottom_symbol = mdl_seq_b[j-1];
                i--;
                j--;
            end
            cols.push_front(c);
        end
        cols[cols.size()-1].last = 1'b1;
        foreach (cols[k]) queue_col(cols[k]);
    endtask

    task automatic predict_item(input oae_pkg::t_in_item it);
        case (oae_pkg::t_action'(it.action))
            oae_pkg::ACT_FIRST: begin
                if (mdl_len_a < oae_pkg::MaxLen) mdl_seq_a[mdl_len_a++] = it.symbol;
                else mdl_ovf = 1'b1;
            end
            oae_pkg::ACT_SECOND: begin
                if (mdl_len_b < oae_pkg::MaxLen) mdl_seq_b[mdl_len_b++] = it.symbol;
                else mdl_ovf = 1'b1;
            end
            oae_pkg::ACT_ALIGN: predict_align();
            default: ;
        endcase
    endtask

    // output checker and receiver stall
    always @(posedge i_clk) begin
        oae_pkg::t_out_item exp_col;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (column_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected column %p", o_out_data);
                end else begin
                    exp_col = column_queue.pop_front();
                    if (o_out_data !== exp_col) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("column mismatch exp %p got %p", exp_col, o_out_data);
                    end
                end
            end
            i_out_ready <= !hold_off && ($urandom_range(99) >= stall_pct_out);
        end
    end

    // leaves valid high after the accepting edge; the next call replaces the item, or an idle drops it
    task automatic send_item(input oae_pkg::t_action act, input logic [7:0] sym);
        oae_pkg::t_in_item it;
        it.action = act;
        it.symbol = sym;
        while ($urandom_range(99) < idle_pct_in) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (column_queue.size() != 0) @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == oae_pkg::CFG_MATCH) mdl_match = val[3:0];
        else mdl_pen = val;
        @(posedge i_clk);
    endtask

    typedef struct {
        oae_pkg::t_action act;
        logic [7:0] sym;
        logic check_now;
        oae_pkg::t_out_item want;
    } t_row;

    t_row directed [$];

    task automatic add_row(input oae_pkg::t_action a, input logic [7:0] s);
        t_row r;
        r.act = a;
        r.sym = s;
        r.check_now = 1'b0;
        r.want = '0;
        directed.insert(directed.size(), r);
    endtask

    task automatic random_burst(input int len_a, input int len_b, input int alpha);
        int k;
        for (k = 0; k < len_a; k++) send_item(oae_pkg::ACT_FIRST, 8'($urandom_range(alpha)));
        for (k = 0; k < len_b; k++) send_item(oae_pkg::ACT_SECOND, 8'($urandom_range(alpha)));
        send_item(oae_pkg::ACT_ALIGN, 8'($urandom));
    endtask

    initial begin
        t_row r;
        oae_pkg::t_out_item fresh;
        int n, ph, k;
        cycles = 0;
        mismatches = 0;
        idle_pct_in = 0;
        stall_pct_out = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        mdl_match = 4'd1;
        mdl_pen = -5'sd2;
        mdl_len_a = 0;
        mdl_len_b = 0;
        mdl_ovf = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty second after reset, empty first, extremes, action 3
        r.act = oae_pkg::ACT_ALIGN; r.sym = 8'h00; r.check_now = 1'b1;
        fresh = '0; fresh.last = 1'b1; fresh.no_alignment = 1'b1;
        r.want = fresh;
        directed.insert(directed.size(), r);
        add_row(oae_pkg::ACT_SECOND, 8'hFF);
        add_row(oae_pkg::ACT_SECOND, 8'h00);
        add_row(oae_pkg::ACT_ALIGN, 8'h00);
        add_row(oae_pkg::ACT_FIRST, 8'hFF);
        add_row(oae_pkg::ACT_FIRST, 8'h00);
        add_row(oae_pkg::ACT_NONE, 8'hAA);
        add_row(oae_pkg::ACT_FIRST, 8'h55);
        add_row(oae_pkg::ACT_SECOND, 8'h55);
        add_row(oae_pkg::ACT_ALIGN, 8'hFF);
        foreach (directed[d]) begin
            if (directed[d].check_now) begin
                queue_col(directed[d].want);
                send_item(directed[d].act, directed[d].sym);
                void'(column_queue.pop_back());
            end else send_item(directed[d].act, directed[d].sym);
        end
        drain();
        write_reg(oae_pkg::CFG_MATCH, 5'd15);
        write_reg(oae_pkg::CFG_PENALTY, 5'b10001);
        send_item(oae_pkg::ACT_ALIGN, 8'h00);
        drain();
        write_reg(oae_pkg::CFG_MATCH, 5'd0);
        write_reg(oae_pkg::CFG_PENALTY, 5'd0);
        send_item(oae_pkg::ACT_ALIGN, 8'h00);
        drain();

        // random phases, sequences kept loaded between aligns
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct_in = 0; stall_pct_out = 0; end
                1: begin idle_pct_in = 45; stall_pct_out = 0; end
                2: begin idle_pct_in = 0; stall_pct_out = 45; end
                default: begin idle_pct_in = 22; stall_pct_out = 22; end
            endcase
            write_reg(oae_pkg::CFG_MATCH, 5'($urandom_range(15)));
            write_reg(oae_pkg::CFG_PENALTY, 5'(-$urandom_range(15)));
            for (n = 0; n < 4; n++) begin
                random_burst($urandom_range(3), $urandom_range(4), (n % 2) ? 3 : 255);
                if (n == 1 && ph == 2) begin
                    hold_off = 1'b1;
                    fork
                        begin
                            repeat (600) @(posedge i_clk);
                            hold_off = 1'b0;
                        end
                        begin
                            send_item(oae_pkg::ACT_SECOND, 8'($urandom));
                            send_item(oae_pkg::ACT_ALIGN, 8'h00);
                            send_item(oae_pkg::ACT_ALIGN, 8'h00);
                            i_in_valid <= 1'b0;
                            @(posedge i_clk);
                        end
                    join
                end
            end
            drain();
        end

        // overflow and full-size case
        write_reg(oae_pkg::CFG_MATCH, 5'd1);
        write_reg(oae_pkg::CFG_PENALTY, 5'b11110);
        for (k = 0; k < 34; k++) send_item(oae_pkg::ACT_FIRST, 8'($urandom_range(3)));
        for (k = 0; k < 33; k++) send_item(oae_pkg::ACT_SECOND, 8'($urandom_range(3)));
        send_item(oae_pkg::ACT_ALIGN, 8'h00);
        drain();

        if (mismatches == 0 && column_queue.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
